[sv/integer_to_ascii_radix_macros.svh]
// assertion macros for the radix text converter
// used by integer_to_ascii_radix; no other dependencies
`ifndef INTEGER_TO_ASCII_RADIX_MACROS_SVH
`define INTEGER_TO_ASCII_RADIX_MACROS_SVH

`ifndef SYNTHESIS
`define ITOA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("itoa same-cycle check failed");
`define ITOA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("itoa next-cycle check failed");
`else
`define ITOA_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define ITOA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[sv/itoa_pkg.sv]
// shared constants, types and the digit glyph function for the radix converter
// no dependencies
package itoa_pkg;

    localparam int WORD_BITS = 32;
    localparam int RADIX_W   = 6;
    localparam int CHAR_W    = 7;
    localparam int LEN_W     = 6;
    localparam int BUF_DEPTH = WORD_BITS;
    localparam int BUF_AW    = $clog2(BUF_DEPTH);
    localparam int STEP_W    = $clog2(WORD_BITS);

    localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_DEC = 6'd10;
    localparam logic [RADIX_W-1:0] DIGIT_MAX = 6'd9;

    localparam logic [CHAR_W-1:0] CH_ZERO    = 7'h30;
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 7'h61;
    localparam logic [CHAR_W-1:0] CH_MINUS   = 7'h2D;

    typedef struct packed {
        logic start;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

    function automatic logic [CHAR_W-1:0] glyph_of(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] g;
        if (d > DIGIT_MAX) begin
            g = CH_LOWER_A + CHAR_W'(d) - CHAR_W'(RADIX_DEC);
        end else begin
            g = CH_ZERO + CHAR_W'(d);
        end
        return g;
    endfunction

endpackage

[sv/itoa_if.sv]
// request channels of the radix converter: number in, characters out
// depends on itoa_pkg
interface itoa_in_if;
    import itoa_pkg::*;
    logic                        valid;
    logic                        ready;
    logic signed [WORD_BITS-1:0] value;
    logic [RADIX_W-1:0]          radix;
    modport source (output valid, value, radix, input ready);
    modport sink   (input valid, value, radix, output ready);
endinterface

interface itoa_out_if;
    import itoa_pkg::*;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] character;
    logic              is_last;
    logic [LEN_W-1:0]  length;
    modport source (output valid, character, is_last, length, input ready);
    modport sink   (input valid, character, is_last, length, output ready);
endinterface

[sv/itoa_div.sv]
// restoring divider, one quotient bit per cycle, word by small radix
// depends on itoa_pkg
module itoa_div (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  itoa_pkg::t_div_ctl                     i_ctl,
    input  logic [itoa_pkg::WORD_BITS-1:0]         i_dividend,
    input  logic [itoa_pkg::RADIX_W-1:0]           i_divisor,
    output itoa_pkg::t_div_sts                     o_sts,
    output logic [itoa_pkg::WORD_BITS-1:0]         o_quotient,
    output logic [itoa_pkg::RADIX_W-1:0]           o_remainder
);
    import itoa_pkg::*;

    logic                  r_busy;
    logic                  r_done;
    logic [STEP_W-1:0]     r_step;
    logic [WORD_BITS-1:0]  r_quo;
    logic [RADIX_W-1:0]    r_rem;
    logic [RADIX_W-1:0]    r_div;
    logic [RADIX_W:0]      w_trial;
    logic                  w_fits;
    logic [RADIX_W-1:0]    n_rem;

    // shift the next dividend bit into the partial remainder
    always_comb begin
        w_trial = {r_rem, r_quo[WORD_BITS-1]};
        w_fits  = (w_trial >= {1'b0, r_div});
        n_rem   = w_fits ? RADIX_W'(w_trial - {1'b0, r_div}) : RADIX_W'(w_trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(WORD_BITS - 1);
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_quo <= {r_quo[WORD_BITS-2:0], w_fits};
                r_rem <= n_rem;
                r_step <= r_step - 1'b1;
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_sts.busy  = r_busy;
    assign o_sts.done  = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

[sv/integer_to_ascii_radix.sv]
// top level of the integer to ascii converter, radix 2 to 36
// depends on itoa_pkg, itoa_if, itoa_div and integer_to_ascii_radix_macros.svh

// Takes one signed word and a radix (values below 2 act as 2, above 36 as 36)
// and sends its text, most significant character first, one character per
// request, with is_last on the final one and the total length on each.
// Radix 10 gives a leading minus for negative values; other radices read the
// bits as unsigned. Digits come from one shared restoring divider that
// produces one quotient bit per cycle, least significant digit first into a
// small character buffer; the buffer is then read back in reverse, each
// character passing through a buffer read, a load into the output register
// and a hold until the sink takes it. The input is not ready until the last
// character of the previous item has been taken.
module integer_to_ascii_radix (
    input  logic       i_clk,
    input  logic       i_rst_n,
    itoa_in_if.sink    i_in,
    itoa_out_if.source o_out
);
    import itoa_pkg::*;

    `include "integer_to_ascii_radix_macros.svh"

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_SIGN,
        S_READ,
        S_LOAD,
        S_HOLD
    } t_state;

    t_state                r_state;
    logic [RADIX_W-1:0]    r_radix;
    logic                  r_neg;
    logic [WORD_BITS-1:0]  r_mag;
    logic                  r_div_start;
    logic [LEN_W-1:0]      r_cnt;
    logic [BUF_AW-1:0]     r_idx;
    logic                  r_out_valid;
    logic [CHAR_W-1:0]     r_out_char;
    logic                  r_out_last;
    logic [LEN_W-1:0]      r_out_len;
    logic [CHAR_W-1:0]     r_rd_data;
    logic [CHAR_W-1:0]     r_buf [BUF_DEPTH];

    logic [RADIX_W-1:0]    w_radix;
    logic                  w_neg;
    logic                  w_accept;
    t_div_ctl              w_div_ctl;
    t_div_sts              w_div_sts;
    logic [WORD_BITS-1:0]  w_quo;
    logic [RADIX_W-1:0]    w_rem;
    logic                  w_we;
    logic [CHAR_W-1:0]     w_wdata;
    logic                  w_re;

    always_comb begin
        priority if (i_in.radix < RADIX_MIN) begin
            w_radix = RADIX_MIN;
        end else if (i_in.radix > RADIX_MAX) begin
            w_radix = RADIX_MAX;
        end else begin
            w_radix = i_in.radix;
        end
        w_neg = (w_radix == RADIX_DEC) && i_in.value[WORD_BITS-1];
    end

    assign i_in.ready = (r_state == S_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_div_ctl.start = r_div_start;

    itoa_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_div_ctl),
        .i_dividend  (r_mag),
        .i_divisor   (r_radix),
        .o_sts       (w_div_sts),
        .o_quotient  (w_quo),
        .o_remainder (w_rem)
    );

    // digits land least significant first, the minus sign after them
    assign w_we    = ((r_state == S_DIV) && w_div_sts.done) || (r_state == S_SIGN);
    assign w_wdata = (r_state == S_SIGN) ? CH_MINUS : glyph_of(w_rem);
    assign w_re    = (r_state == S_READ);

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_buf[r_cnt[BUF_AW-1:0]] <= w_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_re) begin
            r_rd_data <= r_buf[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_radix     <= w_radix;
                        r_neg       <= w_neg;
                        r_mag       <= w_neg ? WORD_BITS'(~i_in.value + 1'b1)
                                             : WORD_BITS'(i_in.value);
                        r_cnt       <= '0;
                        r_div_start <= 1'b1;
                        r_state     <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_div_sts.done) begin
                        r_cnt <= r_cnt + 1'b1;
                        if (w_quo == '0) begin
                            r_idx   <= r_cnt[BUF_AW-1:0];
                            r_state <= r_neg ? S_SIGN : S_READ;
                        end else begin
                            r_mag       <= w_quo;
                            r_div_start <= 1'b1;
                        end
                    end
                end
                S_SIGN: begin
                    r_cnt   <= r_cnt + 1'b1;
                    r_idx   <= r_cnt[BUF_AW-1:0];
                    r_state <= S_READ;
                end
                S_READ: begin
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    r_out_valid <= 1'b1;
                    r_out_char  <= r_rd_data;
                    r_out_last  <= (r_idx == '0);
                    r_out_len   <= r_cnt;
                    r_state     <= S_HOLD;
                end
                S_HOLD: begin
                    if (o_out.ready) begin
                        r_out_valid <= 1'b0;
                        if (r_out_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx   <= r_idx - 1'b1;
                            r_state <= S_READ;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.character = r_out_char;
    assign o_out.is_last   = r_out_last;
    assign o_out.length    = r_out_len;

    `ITOA_ASSERT_SAME(a_no_overlap, i_clk, i_rst_n, o_out.valid, !i_in.ready)
    `ITOA_ASSERT_NEXT(a_last_frees_input, i_clk, i_rst_n,
        o_out.valid && o_out.ready && o_out.is_last, i_in.ready)
    `ITOA_ASSERT_SAME(a_div_done_in_div, i_clk, i_rst_n, w_div_sts.done, r_state == S_DIV)
    `ITOA_ASSERT_SAME(a_len_in_range, i_clk, i_rst_n, o_out.valid,
        (o_out.length != '0) && (o_out.length <= LEN_W'(BUF_DEPTH)))

endmodule

[test/itoa_text_checker.sv]
// checker for the radix text converter: predicts each number's characters and
// compares them with what leaves the output channel; depends on itoa_pkg, itoa_if
module itoa_text_checker
    import itoa_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    itoa_in_if   i_in,
    itoa_out_if  i_out,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [CHAR_W-1:0] character;
        logic              is_last;
        logic [LEN_W-1:0]  length;
    } t_text_char;

    t_text_char expected_chars[$];
    int         mismatches = 0;

    // text of one number, most significant character first, onto the expected store
    function automatic void predict_text(input logic [WORD_BITS-1:0] value,
                                         input logic [RADIX_W-1:0]   radix);
        logic [WORD_BITS-1:0] mag;
        logic [WORD_BITS-1:0] base;
        logic [WORD_BITS-1:0] digit;
        logic [CHAR_W-1:0]    glyphs[$];
        logic                 negative;
        t_text_char           rec;
        int                   total;
        if (radix < RADIX_MIN) begin
            base = WORD_BITS'(RADIX_MIN);
        end else if (radix > RADIX_MAX) begin
            base = WORD_BITS'(RADIX_MAX);
        end else begin
            base = WORD_BITS'(radix);
        end
        negative = (base == WORD_BITS'(RADIX_DEC)) && value[WORD_BITS-1];
        // unsigned negate gives the right magnitude for the most negative value too
        mag = negative ? (~value + 1'b1) : value;
        do begin
            digit = mag % base;
            if (digit < WORD_BITS'(RADIX_DEC)) begin
                glyphs.push_front(CH_ZERO + CHAR_W'(digit));
            end else begin
                glyphs.push_front(CH_LOWER_A + CHAR_W'(digit - WORD_BITS'(RADIX_DEC)));
            end
            mag = mag / base;
        end while (mag != 0);
        if (negative) begin
            glyphs.push_front(CH_MINUS);
        end
        total = glyphs.size();
        for (int k = 0; k < total; k++) begin
            rec.character = glyphs[k];
            rec.is_last   = (k == total - 1);
            rec.length    = LEN_W'(total);
            expected_chars.push_back(rec);
        end
    endfunction

    always @(posedge i_clk) begin
        t_text_char want;
        if (i_rst_n) begin
            if (i_in.valid && i_in.ready) begin
                predict_text(i_in.value, i_in.radix);
            end
            if (i_out.valid && i_out.ready) begin
                if (expected_chars.size() == 0) begin
                    $error("unexpected character %h with no number outstanding",
                           i_out.character);
                    mismatches++;
                end else begin
                    want = expected_chars.pop_front();
                    if (i_out.character !== want.character) begin
                        $error("character: expected %h, got %h",
                               want.character, i_out.character);
                        mismatches++;
                    end
                    if (i_out.is_last !== want.is_last) begin
                        $error("is_last: expected %0b, got %0b", want.is_last, i_out.is_last);
                        mismatches++;
                    end
                    if (i_out.length !== want.length) begin
                        $error("length: expected %0d, got %0d", want.length, i_out.length);
                        mismatches++;
                    end
                end
            end
        end
        o_pending    <= expected_chars.size();
        o_fail_count <= mismatches;
    end

endmodule

[test/integer_to_ascii_radix_tb.sv]
// top of the radix converter testbench: clock, reset, number requests and the verdict
// depends on itoa_pkg, itoa_if, integer_to_ascii_radix and itoa_text_checker
module integer_to_ascii_radix_tb;
    import itoa_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_NUMBERS = 330;
    localparam int STALL_LIMIT    = 6000;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   quiet_cycles;
    bit   steady;

    itoa_in_if  in_ch();
    itoa_out_if out_ch();

    integer_to_ascii_radix DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    itoa_text_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n      = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.value  = '0;
        in_ch.radix  = RADIX_DEC;
        out_ch.ready = 1'b0;
        steady       = 1'b0;
    end

    // hang detection: no request moving on either side for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL integer_to_ascii_radix");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // character sink with a random stall before each request, none in steady stretches
    initial begin
        int stall;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 3);
            if (stall != 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_ch.valid) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    task automatic send_number(input logic [WORD_BITS-1:0] value,
                               input logic [RADIX_W-1:0]   radix);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 3);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.value <= value;
        in_ch.radix <= radix;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [WORD_BITS-1:0] random_value();
        logic [WORD_BITS-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom;
            4, 5:       v = $urandom_range(0, 1000);
            6, 7:       v = -WORD_BITS'($urandom_range(1, 1000));
            8:          v = {1'b1, {(WORD_BITS-1){1'b0}}} + WORD_BITS'($urandom_range(0, 3));
            default:    v = {1'b0, {(WORD_BITS-1){1'b1}}} - WORD_BITS'($urandom_range(0, 3));
        endcase
        return v;
    endfunction

    function automatic logic [RADIX_W-1:0] random_radix();
        logic [RADIX_W-1:0] r;
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4:       r = RADIX_DEC;
            5, 6:                r = RADIX_MIN;
            7:                   r = RADIX_W'($urandom_range(0, 63));
            default:             r = RADIX_W'($urandom_range(RADIX_MIN, RADIX_MAX));
        endcase
        return r;
    endfunction

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // zero, ones, the extremes and out-of-range radices
        send_number(32'd0, RADIX_DEC);
        send_number(32'd0, RADIX_MIN);
        send_number(32'd1, RADIX_MIN);
        send_number(32'hFFFF_FFFF, RADIX_DEC);
        send_number(32'hFFFF_FFFF, RADIX_MIN);
        send_number(32'hFFFF_FFFF, 6'd16);
        send_number(32'h8000_0000, RADIX_DEC);
        send_number(32'h8000_0000, RADIX_MIN);
        send_number(32'h8000_0001, RADIX_DEC);
        send_number(32'h7FFF_FFFF, RADIX_DEC);
        send_number(32'h7FFF_FFFF, RADIX_MAX);
        send_number(32'hFFFF_FFFF, RADIX_MAX);
        send_number(32'd35, RADIX_MAX);
        send_number(32'd36, RADIX_MAX);
        send_number(32'd255, 6'd16);
        send_number(-32'sd123, 6'd16);
        send_number(-32'sd123, RADIX_DEC);
        send_number(32'd123456789, RADIX_DEC);
        send_number(32'd9, RADIX_DEC);
        send_number(32'd10, RADIX_DEC);
        send_number(32'd5, 6'd0);
        send_number(32'd5, 6'd1);
        send_number(32'd1295, 6'd37);
        send_number(32'hDEAD_BEEF, 6'd63);
        send_number(32'd80, 6'd3);

        for (int n = 0; n < RANDOM_NUMBERS; n++) begin
            // alternate stretches with and without idling on both sides
            if (n % 40 == 0) begin
                steady = (n % 80 == 40);
            end
            send_number(random_value(), random_radix());
        end
        in_ch.valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS integer_to_ascii_radix");
        end else begin
            $display("FAIL integer_to_ascii_radix");
        end
        $finish;
    end

endmodule
